// File: design/fpa_pkg.sv
// shared constants, operation codes and cell type for the fixed-point alu
`timescale 1ns / 1ps
package fpa_pkg;
  localparam int WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W = WIDTH + FRAC_BITS;
  localparam int STAGES = NUM_W;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MIN = 4'd4;
  localparam logic [3:0] OP_MAX = 4'd5;
  localparam logic [3:0] OP_ABS = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_LE  = 4'd8;
  localparam logic [3:0] OP_GT  = 4'd9;
  localparam logic [3:0] OP_GE  = 4'd10;

  typedef struct packed {
    logic              vld;
    logic [3:0]        kind;
    logic [WIDTH-1:0]  res;
    logic              is_true;
    logic              dz;
    logic              neg;
    logic [WIDTH-1:0]  den;
    logic [WIDTH:0]    rem;
    logic [NUM_W-1:0]  num;
  } cell_t;
endpackage

// File: design/fpa_cell.sv
// one restoring division step; carries the item along the chain
`timescale 1ns / 1ps
module fpa_cell
  import fpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t d_in,
  output cell_t d_out
);
  cell_t            r_r;
  cell_t            r_nxt;
  logic [WIDTH:0]   sh;
  logic [WIDTH+1:0] diff;

  always_comb begin
    r_nxt = d_in;
    sh = {d_in.rem[WIDTH-1:0], d_in.num[NUM_W-1]};
    diff = {1'b0, sh} - {2'b0, d_in.den};
    r_nxt.num = {d_in.num[NUM_W-2:0], 1'b0};
    if (!diff[WIDTH+1]) begin
      r_nxt.rem = diff[WIDTH:0];
      r_nxt.num[0] = 1'b1;
    end else begin
      r_nxt.rem = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r.vld <= 1'b0;
    end else if (en) begin
      r_r <= r_nxt;
    end
  end

  assign d_out = r_r;
endmodule

// File: design/fpa_front.sv
// decode stage: non-divide operations and divide operand setup
`timescale 1ns / 1ps
module fpa_front
  import fpa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld,
  input  logic [3:0]              kind,
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output cell_t                   d_out
);
  cell_t                     r_r;
  cell_t                     r_nxt;
  logic signed [WIDTH-1:0]   diff;
  logic signed [2*WIDTH-1:0] prod;
  logic [WIDTH-1:0]          ma;
  logic [WIDTH-1:0]          mb;

  always_comb begin
    diff = a - b;
    prod = a * b;
    ma = a[WIDTH-1] ? WIDTH'(-a) : a;
    mb = b[WIDTH-1] ? WIDTH'(-b) : b;
    r_nxt = '0;
    r_nxt.vld = vld;
    r_nxt.kind = kind;
    r_nxt.neg = a[WIDTH-1] ^ b[WIDTH-1];
    r_nxt.den = mb;
    r_nxt.num = {ma, {FRAC_BITS{1'b0}}};
    case (kind)
      OP_ADD: r_nxt.res = a + b;
      OP_SUB: r_nxt.res = diff;
      OP_MUL: r_nxt.res = prod[FRAC_BITS +: WIDTH];
      OP_DIV: r_nxt.dz = (b == '0);
      OP_MIN: r_nxt.res = (b < a) ? b : a;
      OP_MAX: r_nxt.res = (b < a) ? a : b;
      OP_ABS: r_nxt.res = ma;
      OP_LT:  r_nxt.is_true = diff[WIDTH-1];
      OP_LE:  r_nxt.is_true = diff[WIDTH-1] || diff == '0;
      OP_GT:  r_nxt.is_true = !diff[WIDTH-1] && diff != '0;
      OP_GE:  r_nxt.is_true = !diff[WIDTH-1];
      default: r_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r.vld <= 1'b0;
    end else if (en) begin
      r_r <= r_nxt;
    end
  end

  assign d_out = r_r;
endmodule

// File: design/fixed_point_alu.sv
// divider: one division step per cell; operand and result values are signed Q16.16
// throughput: one request per cycle; the whole chain advances together and halts when
// the output holds a result that is not taken
// reset: rst_n synchronous active low clears all valid flags; payload is not reset
// top level of the fixed-point alu: decode stage, divider cell row and output stage
`timescale 1ns / 1ps
module fixed_point_alu
  import fpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // kind[3:0], operand_a[35:4], operand_b[67:36], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // value[31:0], is_true[32], div_by_zero[33], zeros
);
  cell_t            ch [STAGES+1];
  logic             en;
  logic             vld_r;
  logic [WIDTH-1:0] val_r;
  logic [WIDTH-1:0] val_nxt;
  logic [WIDTH-1:0] q;
  logic             t_r;
  logic             dz_r;
  cell_t            e;

  assign en = !vld_r || out_tready;
  assign in_tready = en;

  fpa_front u_front (
    .clk, .rst_n, .en,
    .vld  (in_tvalid),
    .kind (in_tdata[3:0]),
    .a    (in_tdata[35:4]),
    .b    (in_tdata[67:36]),
    .d_out(ch[0])
  );

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    fpa_cell u_cell (.clk, .rst_n, .en, .d_in(ch[i]), .d_out(ch[i+1]));
  end

  assign e = ch[STAGES];

  always_comb begin
    q = e.num[WIDTH-1:0];
    val_nxt = e.res;
    if (e.kind == OP_DIV) begin
      val_nxt = e.dz ? '0 : (e.neg ? WIDTH'(-q) : q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= e.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      t_r <= e.is_true;
      dz_r <= e.dz;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {6'b0, dz_r, t_r, val_r};

`ifndef ASSERT_OFF
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");
  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[31:0] == '0) else $error("dz value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
`endif
endmodule
